// ----- sv/ttse_pkg.sv -----
// Shared types and codes for the tracked tag stream extractor.
// No dependencies; every other file of the block but ttse_ifs.sv refers to it by scoped names.
package ttse_pkg;

	localparam int MAX_NAME_CHARS_DEF = 16;

	localparam int NUM_TAGS  = 3;
	localparam int MASK_W    = 3;
	localparam int PADDR_W   = 3;

	// register indexes (byte address is 4 * index)
	localparam logic REG_TRACKED_MASK = 1'b0;
	localparam logic [MASK_W-1:0] MASK_RESET = 3'b111;

	// event kinds
	localparam logic [1:0] EV_CONTENT = 2'd0;
	localparam logic [1:0] EV_OPENED  = 2'd1;
	localparam logic [1:0] EV_CLOSED  = 2'd2;
	localparam logic [1:0] EV_CLEARED = 2'd3;

	// tag ids; NO_SECTION marks no open section
	localparam logic [1:0] TAG_THOUGHT = 2'd0;
	localparam logic [1:0] TAG_FINAL   = 2'd1;
	localparam logic [1:0] TAG_TOOL    = 2'd2;
	localparam logic [1:0] NO_SECTION  = 2'd3;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [1:0] tag_id;
		logic [7:0] data_byte;
	} result_t;

endpackage

// ----- sv/ttse_ifs.sv -----
// Valid/ready channel interfaces for the byte input and the event output.
// Depends on nothing; widths follow the fields of one item.
interface ttse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       restart;

	modport source (output valid, ch, restart, input ready);
	modport sink (input valid, ch, restart, output ready);
endinterface

interface ttse_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic [1:0] tag_id;
	logic [7:0] data_byte;

	modport source (output valid, event_kind, tag_id, data_byte, input ready);
	modport sink (input valid, event_kind, tag_id, data_byte, output ready);
endinterface

// ----- sv/ttse_cfg.sv -----
// APB-style configuration register: holds tracked_mask.
// Depends on ttse_pkg.
module ttse_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ttse_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output logic [ttse_pkg::MASK_W-1:0]     tracked_mask
);

	logic [ttse_pkg::MASK_W-1:0] mask_q;
	logic                        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == ttse_pkg::REG_TRACKED_MASK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= ttse_pkg::MASK_RESET;
		end else if (wr_en) begin
			mask_q <= pwdata[ttse_pkg::MASK_W-1:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == ttse_pkg::REG_TRACKED_MASK) begin
			prdata = {{(32-ttse_pkg::MASK_W){1'b0}}, mask_q};
		end
	end

	assign tracked_mask = mask_q;

endmodule

// ----- sv/ttse_parser.sv -----
// Markup parser: parse state registers and the per-byte next-state logic.
// Depends on ttse_pkg; matches names against the three fixed tags in parallel.
module ttse_parser #(
	parameter int MAX_NAME_CHARS = ttse_pkg::MAX_NAME_CHARS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [7:0]                  ch,
	input  logic                        restart,
	input  logic [ttse_pkg::MASK_W-1:0] tracked_mask,
	output logic                        res_valid,
	output ttse_pkg::result_t           res
);

	localparam int NW = $clog2(MAX_NAME_CHARS + 1);
	localparam logic [NW-1:0] POS_MAX = NW'(MAX_NAME_CHARS);

	function automatic logic [3:0] tag_len(input int unsigned i);
		case (i)
			0:       tag_len = 4'd7;
			1:       tag_len = 4'd12;
			default: tag_len = 4'd4;
		endcase
	endfunction

	function automatic logic [7:0] tag_char(input int unsigned i, input logic [3:0] p);
		logic [7:0] c;
		c = 8'h00;
		case (i)
			0: begin
				case (p)
					4'd0: c = "t"; 4'd1: c = "h"; 4'd2: c = "o"; 4'd3: c = "u";
					4'd4: c = "g"; 4'd5: c = "h"; 4'd6: c = "t";
					default: c = 8'h00;
				endcase
			end
			1: begin
				case (p)
					4'd0: c = "f"; 4'd1: c = "i"; 4'd2: c = "n"; 4'd3: c = "a";
					4'd4: c = "l"; 4'd5: c = "_"; 4'd6: c = "a"; 4'd7: c = "n";
					4'd8: c = "s"; 4'd9: c = "w"; 4'd10: c = "e"; 4'd11: c = "r";
					default: c = 8'h00;
				endcase
			end
			default: begin
				case (p)
					4'd0: c = "t"; 4'd1: c = "o"; 4'd2: c = "o"; 4'd3: c = "l";
					default: c = 8'h00;
				endcase
			end
		endcase
		return c;
	endfunction

	logic                        in_markup_q, in_markup_d;
	logic [1:0]                  open_q, open_d;
	logic [NW-1:0]               pos_q, pos_d;
	logic                        name_fin_q, name_fin_d;
	logic                        closing_q, closing_d;
	logic [ttse_pkg::NUM_TAGS-1:0] cand_q, cand_d;
	logic                        slash_q, slash_d;

	// state after an optional restart
	logic                        im_e;
	logic [1:0]                  open_e;
	logic [NW-1:0]               pos_e;
	logic                        nf_e, cf_e, sl_e;
	logic [ttse_pkg::NUM_TAGS-1:0] cand_e;

	logic [ttse_pkg::NUM_TAGS-1:0] len_hit, chr_hit, final_bits, tracked;
	logic [1:0]                  pick;

	always_comb begin
		im_e   = in_markup_q;
		open_e = open_q;
		pos_e  = pos_q;
		nf_e   = name_fin_q;
		cf_e   = closing_q;
		cand_e = cand_q;
		sl_e   = slash_q;
		if (restart) begin
			im_e   = 1'b0;
			open_e = ttse_pkg::NO_SECTION;
			pos_e  = '0;
			nf_e   = 1'b0;
			cf_e   = 1'b0;
			cand_e = '1;
			sl_e   = 1'b0;
		end

		for (int i = 0; i < ttse_pkg::NUM_TAGS; i++) begin
			len_hit[i] = cand_e[i] && (pos_e == NW'(tag_len(i)));
			chr_hit[i] = cand_e[i] && (pos_e < NW'(tag_len(i))) &&
			             (tag_char(i, pos_e[3:0]) == ch);
		end

		final_bits = nf_e ? cand_e : len_hit;
		tracked    = final_bits & tracked_mask;
		if (tracked[0]) begin
			pick = ttse_pkg::TAG_THOUGHT;
		end else if (tracked[1]) begin
			pick = ttse_pkg::TAG_FINAL;
		end else begin
			pick = ttse_pkg::TAG_TOOL;
		end

		in_markup_d = im_e;
		open_d      = open_e;
		pos_d       = pos_e;
		name_fin_d  = nf_e;
		closing_d   = cf_e;
		cand_d      = cand_e;
		slash_d     = sl_e;
		res_valid   = 1'b0;
		res         = '{event_kind: ttse_pkg::EV_CONTENT, tag_id: open_e, data_byte: 8'd0};

		if (!im_e) begin
			if (ch == ttse_pkg::CH_LT) begin
				in_markup_d = 1'b1;
				pos_d       = '0;
				name_fin_d  = 1'b0;
				closing_d   = 1'b0;
				cand_d      = '1;
				slash_d     = 1'b0;
			end else if (open_e != ttse_pkg::NO_SECTION) begin
				res_valid     = 1'b1;
				res.data_byte = ch;
			end
		end else if (ch != ttse_pkg::CH_GT) begin
			if (pos_e == '0 && !nf_e && !cf_e && ch == ttse_pkg::CH_SLASH) begin
				closing_d = 1'b1;
			end else if (!nf_e) begin
				if (ch == ttse_pkg::CH_SPACE) begin
					cand_d     = len_hit;
					name_fin_d = 1'b1;
				end else begin
					cand_d = chr_hit;
					if (pos_e < POS_MAX) begin
						pos_d = pos_e + NW'(1);
					end
				end
			end
			slash_d = (ch == ttse_pkg::CH_SLASH);
		end else begin
			// closing bracket: decide what the tag did
			in_markup_d = 1'b0;
			if (cf_e) begin
				if (open_e != ttse_pkg::NO_SECTION && final_bits[open_e]) begin
					res_valid      = 1'b1;
					res.event_kind = ttse_pkg::EV_CLOSED;
					open_d         = ttse_pkg::NO_SECTION;
				end
			end else if (tracked != '0) begin
				res_valid  = 1'b1;
				res.tag_id = pick;
				if (sl_e) begin
					res.event_kind = ttse_pkg::EV_CLEARED;
				end else begin
					res.event_kind = ttse_pkg::EV_OPENED;
					open_d         = pick;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_markup_q <= 1'b0;
			open_q      <= ttse_pkg::NO_SECTION;
			pos_q       <= '0;
			name_fin_q  <= 1'b0;
			closing_q   <= 1'b0;
			cand_q      <= '1;
			slash_q     <= 1'b0;
		end else if (accept) begin
			in_markup_q <= in_markup_d;
			open_q      <= open_d;
			pos_q       <= pos_d;
			name_fin_q  <= name_fin_d;
			closing_q   <= closing_d;
			cand_q      <= cand_d;
			slash_q     <= slash_d;
		end
	end

endmodule

// ----- sv/ttse_out_buf.sv -----
// Two-entry result buffer: output register plus skid entry.
// Depends on ttse_pkg for the result item type.
module ttse_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ttse_pkg::result_t push_item,
	input  logic              pop_ready,
	output logic              full,
	output logic              head_valid,
	output ttse_pkg::result_t head
);

	ttse_pkg::result_t e0_q, e1_q;
	logic [1:0]        count_q;
	logic              pop;

	assign head_valid = (count_q != 2'd0);
	assign full       = (count_q == 2'd2);
	assign pop        = head_valid && pop_ready;
	assign head       = e0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push && !pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop && !push) begin
			count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (count_q == 2'd0) begin
				e0_q <= push_item;
			end else begin
				e1_q <= push_item;
			end
		end else if (pop && !push) begin
			e0_q <= e1_q;
		end else if (pop && push) begin
			if (count_q == 2'd1) begin
				e0_q <= push_item;
			end else begin
				e0_q <= e1_q;
				e1_q <= push_item;
			end
		end
	end

endmodule

// ----- sv/tracked_tag_stream_extractor.sv -----
// Tracked tag stream extractor: sorts a byte stream by <markup>.
// Takes one byte per cycle while the result buffer has a free entry. An
// event is written into the buffer when its byte is accepted and shows on
// the output channel from there. Bytes that cause no event leave nothing.
// Asynchronous active-low reset: no section open, outside markup, mask = 7.
// The two-entry result buffer lets bytes flow while one event waits.
module tracked_tag_stream_extractor #(
	parameter int MAX_NAME_CHARS = ttse_pkg::MAX_NAME_CHARS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ttse_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	ttse_in_if.sink                      text,
	ttse_out_if.source                   events
);

	logic [ttse_pkg::MASK_W-1:0] tracked_mask;
	logic                        accept;
	logic                        res_valid;
	ttse_pkg::result_t           res;
	logic                        buf_full;
	logic                        head_valid;
	ttse_pkg::result_t           head;

	// Configuration register; the user writes it only while the block is idle; the block does not enforce this.
	ttse_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.tracked_mask (tracked_mask)
	);

	// Take a byte whenever the buffer has a free entry, so at most one event
	// per byte always fits.
	assign text.ready = !buf_full;
	assign accept     = text.valid && !buf_full;

	ttse_parser #(
		.MAX_NAME_CHARS (MAX_NAME_CHARS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.ch           (text.ch),
		.restart      (text.restart),
		.tracked_mask (tracked_mask),
		.res_valid    (res_valid),
		.res          (res)
	);

	ttse_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept && res_valid),
		.push_item  (res),
		.pop_ready  (events.ready),
		.full       (buf_full),
		.head_valid (head_valid),
		.head       (head)
	);

	assign events.valid      = head_valid;
	assign events.event_kind = head.event_kind;
	assign events.tag_id     = head.tag_id;
	assign events.data_byte  = head.data_byte;

endmodule
